// ===== design/uart_pkg.sv =====
// shared types and constants for the 8n1 uart core
// no dependencies; used by uart_tx_unit, uart_rx_unit and uart_8n1_tx_rx_core
`default_nettype none

package uart_pkg;

    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int RXCNT_W  = PERIOD_W + 1;
    localparam int FRAME_W  = 10;
    localparam int BITCNT_W = 4;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET  = 16'd104;
    localparam logic [PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd52;

    localparam logic [FRAME_W-1:0]  STOP_MARK   = 10'd512;
    localparam logic [FRAME_W-1:0]  FRAME_IDLE  = 10'h3FF;
    localparam logic [BITCNT_W-1:0] FRAME_BITS  = 4'd10;
    localparam logic [BITCNT_W-1:0] RX_SAMPLES  = 4'd9;
    localparam logic [BITCNT_W-1:0] RX_DATA_END = 4'd8;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 1'b1;

    typedef struct packed {
        logic              rx_line;
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              clear_received;
    } t_in_item;

    typedef struct packed {
        logic              tx_line;
        logic              tx_busy;
        logic [BYTE_W-1:0] received_byte;
        logic              received_ready;
    } t_out_item;

    typedef struct packed {
        logic tx_line;
        logic tx_busy;
    } t_tx_status;

    typedef struct packed {
        logic [BYTE_W-1:0] received_byte;
        logic              received_ready;
    } t_rx_status;

endpackage

`default_nettype wire

// ===== design/uart_tx_unit.sv =====
// 8n1 transmitter: frame shift register, bit counter and bit timer
// depends on uart_pkg
`default_nettype none

module uart_tx_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire uart_pkg::t_in_item            i_item,
    input  wire logic [uart_pkg::PERIOD_W-1:0] i_bit_period,
    output uart_pkg::t_tx_status               o_status
);

    logic [uart_pkg::FRAME_W-1:0]  r_frame,     n_frame;
    logic [uart_pkg::BITCNT_W-1:0] r_bits_left, n_bits_left;
    logic [uart_pkg::PERIOD_W-1:0] r_tick,      n_tick;

    always_comb begin
        n_frame     = r_frame;
        n_bits_left = r_bits_left;
        n_tick      = r_tick;
        if (r_bits_left != '0) begin
            n_tick = r_tick + 1'b1;
            if (n_tick >= i_bit_period) begin
                n_tick      = '0;
                n_frame     = {1'b1, r_frame[uart_pkg::FRAME_W-1:1]};
                n_bits_left = r_bits_left - 1'b1;
            end
        end
        // a send is taken once the stop bit has ended, even in the same beat
        if (n_bits_left == '0 && i_item.send_valid) begin
            n_frame     = {1'b0, i_item.send_byte, 1'b0} + uart_pkg::STOP_MARK;
            n_bits_left = uart_pkg::FRAME_BITS;
            n_tick      = '0;
        end
    end

    always_comb begin
        o_status.tx_busy = (n_bits_left != '0);
        o_status.tx_line = (n_bits_left != '0) ? n_frame[0] : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= uart_pkg::FRAME_IDLE;
            r_bits_left <= '0;
            r_tick      <= '0;
        end else if (i_step) begin
            r_frame     <= n_frame;
            r_bits_left <= n_bits_left;
            r_tick      <= n_tick;
        end
    end

    a_bits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= uart_pkg::FRAME_BITS)
        else $error("tx bit counter beyond frame length");

endmodule

`default_nettype wire

// ===== design/uart_rx_unit.sv =====
// 8n1 receiver: start edge detect, sample timer and held byte with ready flag
// depends on uart_pkg
`default_nettype none

module uart_rx_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire uart_pkg::t_in_item            i_item,
    input  wire logic [uart_pkg::PERIOD_W-1:0] i_bit_period,
    input  wire logic [uart_pkg::PERIOD_W-1:0] i_half_period,
    output uart_pkg::t_rx_status               o_status
);

    logic                          r_active, n_active;
    logic [uart_pkg::RXCNT_W-1:0]  r_tick,   n_tick;
    logic [uart_pkg::BITCNT_W-1:0] r_index,  n_index;
    logic [uart_pkg::BYTE_W-1:0]   r_byte,   n_byte;
    logic                          r_ready,  n_ready;
    logic                          r_last,   n_last;
    logic [uart_pkg::RXCNT_W-1:0]  w_target;

    always_comb begin
        // first sample lands mid-bit, later ones one period apart
        w_target = (r_index == '0)
            ? ({1'b0, i_half_period} + {1'b0, i_bit_period})
            : {1'b0, i_bit_period};

        n_active = r_active;
        n_tick   = r_tick;
        n_index  = r_index;
        n_byte   = r_byte;
        n_ready  = r_ready;
        n_last   = i_item.rx_line;

        if (i_item.clear_received) begin
            n_ready = 1'b0;
            n_byte  = '0;
        end

        if (r_active) begin
            n_tick = r_tick + 1'b1;
            if (n_tick >= w_target) begin
                n_tick = '0;
                if (r_index < uart_pkg::RX_DATA_END && i_item.rx_line) begin
                    n_byte[r_index[2:0]] = 1'b1;
                end
                n_index = r_index + 1'b1;
                if (n_index >= uart_pkg::RX_SAMPLES) begin
                    n_active = 1'b0;
                    n_index  = '0;
                    n_ready  = 1'b1;
                end
            end
        end else if (r_last && !i_item.rx_line) begin
            n_active = 1'b1;
            n_tick   = '0;
            n_index  = '0;
        end
    end

    assign o_status.received_byte  = n_byte;
    assign o_status.received_ready = n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tick   <= '0;
            r_index  <= '0;
            r_byte   <= '0;
            r_ready  <= 1'b0;
            r_last   <= 1'b1;
        end else if (i_step) begin
            r_active <= n_active;
            r_tick   <= n_tick;
            r_index  <= n_index;
            r_byte   <= n_byte;
            r_ready  <= n_ready;
            r_last   <= n_last;
        end
    end

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= uart_pkg::RX_DATA_END)
        else $error("rx sample index beyond stop sample");

    a_idle_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_index == '0))
        else $error("rx sample index left nonzero while idle");

endmodule

`default_nettype wire

// ===== design/uart_8n1_tx_rx_core.sv =====
// top level of the 8n1 uart core: input register, tx and rx units, result register
// depends on uart_pkg, uart_tx_unit and uart_rx_unit
`default_nettype none

// Each input beat is one clock tick carrying the rx pin level, an optional byte to
// send and a clear pulse; each produces exactly one result beat with the tx pin
// level, tx busy, the held received byte and the ready flag after that tick. One beat
// is taken every cycle while o_in_stall is low. The input register holds the beat,
// the tx and rx state is updated once as it passes on, and the result register loads
// it when that register is empty or not stalled. A stall on the result side holds the
// result register, and once the input register is also full it stalls the input
// side in the same cycle. The user must write bit_period and half_period through
// the configuration port only while no beat is in flight; the block itself does
// not enforce it.
module uart_8n1_tx_rx_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire uart_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output uart_pkg::t_out_item                   o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [uart_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [uart_pkg::PERIOD_W-1:0]    i_cfg_data
);

    logic [uart_pkg::PERIOD_W-1:0] r_bit_period;
    logic [uart_pkg::PERIOD_W-1:0] r_half_period;
    logic                          r_in_valid;
    uart_pkg::t_in_item            r_in_item;
    logic                          r_out_valid;
    uart_pkg::t_out_item           r_out_item;
    logic                          w_advance;
    uart_pkg::t_tx_status          w_tx_status;
    uart_pkg::t_rx_status          w_rx_status;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= uart_pkg::BIT_PERIOD_RESET;
            r_half_period <= uart_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uart_pkg::CFG_BIT_PERIOD:  r_bit_period  <= i_cfg_data;
                uart_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    uart_tx_unit u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_item       (r_in_item),
        .i_bit_period (r_bit_period),
        .o_status     (w_tx_status)
    );

    uart_rx_unit u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_item        (r_in_item),
        .i_bit_period  (r_bit_period),
        .i_half_period (r_half_period),
        .o_status      (w_rx_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item.tx_line        <= w_tx_status.tx_line;
            r_out_item.tx_busy        <= w_tx_status.tx_busy;
            r_out_item.received_byte  <= w_rx_status.received_byte;
            r_out_item.received_ready <= w_rx_status.received_ready;
        end
    end

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no beat held");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced beat did not reach the result register");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.tx_busy) |-> r_out_item.tx_line)
        else $error("tx line low while transmitter idle");

endmodule

`default_nettype wire
